// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define WSRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that is also evaluated during reset.
`define WSRD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: rtl/wsrd_pkg.sv
// Package with the operation codes, status codes and shared types of the deque.
`timescale 1ns / 1ps

package wsrd_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STEAL = 2'd2;

    // Status codes carried in the status field.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Outcome of one decoded operation, passed from the control unit to the pipeline.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                take;
    } op_result_t;

endpackage

// File: rtl/wsrd_if.sv
// Valid/ready channel interfaces for the request and response beats of the deque.
`timescale 1ns / 1ps

interface wsrd_req_if #(
    parameter int JOB_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [wsrd_pkg::FUNC_W-1:0]   func;
    logic [JOB_WIDTH-1:0]          job_in;

    modport source (output valid, output func, output job_in, input ready);
    modport sink   (input valid, input func, input job_in, output ready);
endinterface

interface wsrd_rsp_if #(
    parameter int JOB_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [wsrd_pkg::STATUS_W-1:0] status;
    logic [JOB_WIDTH-1:0]          job_out;

    modport source (output valid, output status, output job_out, input ready);
    modport sink   (input valid, input status, input job_out, output ready);
endinterface

// File: rtl/work_stealing_ring_deque_top.sv
// Top level of the work-stealing ring deque: request decode, slot memory and result stage.
`timescale 1ns / 1ps

// The block holds DEPTH job slots in a ring and serves as a work-stealing
// deque. The owner pushes jobs at the head and pops them back, last in first
// out; thieves steal from the tail, first in first out. Each request beat
// carries func (0 push, 1 pop, 2 steal, 3 ignored) and job_in; each request
// yields exactly one response beat with status (0 success, 1 full on push,
// 2 empty on pop or steal) and job_out, which is the removed job on a
// successful pop or steal and zero otherwise. The block takes one request
// every clock cycle as long as the response side does not hold it off; an
// accepted request first passes the access to the single-port slot memory,
// whose read data is registered, and then moves its outcome into the
// response register. Pointers and the occupancy count are updated at the
// accepting edge, so back-to-back requests always see the effect of the one
// before. Responses come out in request order. When the response side
// stalls, one request still sits in the memory stage and one in the response
// register; after that the request side is held off. Reset clears the
// pointers and the occupancy, so the ring starts empty; the slot contents
// need no clearing since a slot is only read after it is written.
module work_stealing_ring_deque_top #(
    parameter int DEPTH     = 16,
    parameter int JOB_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    wsrd_req_if.sink          req,
    wsrd_rsp_if.source        rsp
);
    import wsrd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 accept;
    logic [AW-1:0]        mem_addr;
    logic                 mem_wr;
    logic                 mem_rd;
    logic [JOB_WIDTH-1:0] mem_rd_data;
    op_result_t           op_result;

    // Memory stage: the outcome of the accepted request while its read completes.
    logic                 s1_valid_reg;
    op_result_t           s1_result_reg;
    logic                 s1_advance;

    // Response register.
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [JOB_WIDTH-1:0] out_job_reg;
    logic [JOB_WIDTH-1:0] out_job_next;

    // The memory stage empties whenever the response register is free or
    // being drained in this cycle; a new request can enter behind it then.
    assign s1_advance = s1_valid_reg & (~out_valid_reg | rsp.ready);
    assign req.ready  = ~s1_valid_reg | s1_advance;
    assign accept     = req.valid & req.ready;

    wsrd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .func   (req.func),
        .addr   (mem_addr),
        .mem_wr (mem_wr),
        .mem_rd (mem_rd),
        .result (op_result)
    );

    wsrd_mem #(
        .DEPTH (DEPTH),
        .WIDTH (JOB_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .rd_en   (mem_rd),
        .addr    (mem_addr),
        .wr_data (req.job_in),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_result_reg <= op_result;
        end
    end

    // Only a successful pop or steal shows the slot contents; everything else
    // returns a zero job.
    assign out_job_next = s1_result_reg.take ? mem_rd_data : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (~out_valid_reg | rsp.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_status_reg <= s1_result_reg.status;
            out_job_reg    <= out_job_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.job_out = out_job_reg;

endmodule

// File: rtl/wsrd_mem.sv
// Single-port job slot memory with a registered read.
`timescale 1ns / 1ps

module wsrd_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic             rd_en,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/wsrd_ctrl.sv
// Head, tail and occupancy registers of the ring and the decode of one operation.
`timescale 1ns / 1ps

module wsrd_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [wsrd_pkg::FUNC_W-1:0] func,
    output logic [AW-1:0]               addr,
    output logic                        mem_wr,
    output logic                        mem_rd,
    output wsrd_pkg::op_result_t        result
);
    import wsrd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] tail_inc;
    logic          is_full;
    logic          is_empty;
    logic          do_wr;
    logic          do_rd;

    // The occupied slots always form one arc from tail up to head, so an
    // occupancy count answers the per-slot valid question for every operation.
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        result.status = STATUS_OK;
        result.take   = 1'b0;
        addr          = head_reg;
        do_wr         = 1'b0;
        do_rd         = 1'b0;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        unique case (func)
            FUNC_PUSH:
            begin
                if (is_full)
                begin
                    result.status = STATUS_FULL;
                end
                else
                begin
                    do_wr      = 1'b1;
                    head_next  = head_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_POP:
            begin
                addr = head_dec;
                if (is_empty)
                begin
                    result.status = STATUS_EMPTY;
                end
                else
                begin
                    do_rd       = 1'b1;
                    result.take = 1'b1;
                    head_next   = head_dec;
                    count_next  = count_reg - 1'b1;
                end
            end
            FUNC_STEAL:
            begin
                addr = tail_reg;
                if (is_empty)
                begin
                    result.status = STATUS_EMPTY;
                end
                else
                begin
                    do_rd       = 1'b1;
                    result.take = 1'b1;
                    tail_next   = tail_inc;
                    count_next  = count_reg - 1'b1;
                end
            end
            default:
            begin
                // The unused code leaves the ring alone and reports success.
            end
        endcase
    end

    assign mem_wr = accept & do_wr;
    assign mem_rd = accept & do_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/wsrd_checker.sv
// Port-level checker for the deque and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsrd_checker #(
    parameter int JOB_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [wsrd_pkg::STATUS_W-1:0] rsp_status,
    input logic [JOB_WIDTH-1:0]          rsp_job_out
);
    import wsrd_pkg::*;

    // A response beat that is not taken stays offered.
    `WSRD_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

    // A job only comes back with a successful status.
    `WSRD_ASSERT(a_job_zero, clk, rst_n, rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_job_out == '0), "nonzero job on a failed operation")

    // Reset leaves no response pending in the next cycle.
    `WSRD_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !rsp_valid, "response valid right after reset")

endmodule

bind work_stealing_ring_deque_top wsrd_checker #(
    .JOB_WIDTH (JOB_WIDTH)
) u_wsrd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_job_out (rsp.job_out)
);

// File: tb/testbench.sv
// Self-checking testbench for the work-stealing ring deque: push, pop and steal beats.
`timescale 1ns / 1ps

// The testbench drives request beats from a queue of pending operations and
// checks every response beat against an in-house model of the deque. The
// model is updated at the edge where a request beat is accepted. That is
// the same moment at which the block commits its pointers, so the expected
// responses line up with the block's own request order.
//
// Stimulus starts with a short directed run. It covers removal from an
// empty ring, the unused operation code, the extreme job values, and the
// last in first out and first in first out orders. A long random run then
// follows. The random run is built from episodes that lean toward filling,
// draining or mixing, so the ring reaches both full and empty again and
// again with random job content.
//
// Both channels idle in short random bursts, with calm stretches between.
// Near the end of the run neither side idles.
module testbench;

    import wsrd_pkg::*;

    localparam int DEPTH      = 16;
    localparam int JOB_WIDTH  = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int RANDOM_OPS = 1850;
    localparam int QUIET_TAIL = 150;
    localparam int TIMEOUT_NS = 3_000_000;

    // The block ignores this operation code.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [JOB_WIDTH-1:0] job;
    } deque_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [JOB_WIDTH-1:0] job_out;
    } deque_result_t;

    logic clk;
    logic rst_n;

    wsrd_req_if #(.JOB_WIDTH(JOB_WIDTH)) req_ch ();
    wsrd_rsp_if #(.JOB_WIDTH(JOB_WIDTH)) rsp_ch ();

    work_stealing_ring_deque_top #(
        .DEPTH     (DEPTH),
        .JOB_WIDTH (JOB_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model of the ring: job slots, per-slot occupancy and the two pointers.
    // DEPTH is a power of two here, so the pointers wrap on their own.
    logic [JOB_WIDTH-1:0] slot_job [DEPTH];
    bit                   slot_busy [DEPTH];
    logic [PTR_W-1:0]     head_ptr;
    logic [PTR_W-1:0]     tail_ptr;

    deque_op_t     pending_ops [$];
    deque_result_t expected_results [$];

    int total_ops;
    int accepted_ops;
    int mismatch_count;
    bit req_beat_taken;

    // Idle burst and calm stretch counters. Each set belongs to one driver.
    int req_gap_left;
    int req_calm_left;
    int rsp_gap_left;
    int rsp_calm_left;

    deque_op_t     next_op;
    deque_result_t want;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Apply one operation to the model. Return the response it must produce.
    function automatic deque_result_t apply_deque_op(input logic [FUNC_W-1:0] op,
                                                     input logic [JOB_WIDTH-1:0] job);
        deque_result_t    r;
        logic [PTR_W-1:0] prev_ptr;
        r.status  = STATUS_OK;
        r.job_out = '0;
        prev_ptr  = head_ptr - 1'b1;
        case (op)
            FUNC_PUSH:
            begin
                if (slot_busy[head_ptr])
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    slot_job[head_ptr]  = job;
                    slot_busy[head_ptr] = 1'b1;
                    head_ptr            = head_ptr + 1'b1;
                end
            end
            FUNC_POP:
            begin
                if (!slot_busy[prev_ptr])
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.job_out           = slot_job[prev_ptr];
                    slot_busy[prev_ptr] = 1'b0;
                    head_ptr            = prev_ptr;
                end
            end
            FUNC_STEAL:
            begin
                if (!slot_busy[tail_ptr])
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.job_out           = slot_job[tail_ptr];
                    slot_busy[tail_ptr] = 1'b0;
                    tail_ptr            = tail_ptr + 1'b1;
                end
            end
            default:
            begin
                // The unused code leaves the ring alone and reports success.
            end
        endcase
        return r;
    endfunction

    task automatic queue_op(input logic [FUNC_W-1:0] op, input logic [JOB_WIDTH-1:0] job);
        deque_op_t item;
        item.func = op;
        item.job  = job;
        pending_ops.push_back(item);
        total_ops++;
    endtask

    task automatic note_mismatch(input string what, input logic [JOB_WIDTH-1:0] exp_val,
                                 input logic [JOB_WIDTH-1:0] got_val);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what,
                     exp_val, got_val);
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        int                   counted;
        int                   mode;
        int                   span;
        int                   roll;
        logic [FUNC_W-1:0]    op;
        logic [JOB_WIDTH-1:0] job;

        req_ch.valid  = 1'b0;
        req_ch.func   = FUNC_PUSH;
        req_ch.job_in = '0;
        rsp_ch.ready  = 1'b0;
        rst_n         = 1'b0;

        total_ops      = 0;
        accepted_ops   = 0;
        mismatch_count = 0;
        req_beat_taken = 1'b0;
        req_gap_left   = 0;
        req_calm_left  = 0;
        rsp_gap_left   = 0;
        rsp_calm_left  = 0;
        head_ptr       = '0;
        tail_ptr       = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_job[i]  = '0;
        end

        // Directed part. Removal and the unused code on an empty ring come
        // first. Then extreme jobs go in, and the order in which pop and
        // steal give them back is checked.
        queue_op(FUNC_POP,    32'h0000_0000);
        queue_op(FUNC_STEAL,  32'hFFFF_FFFF);
        queue_op(FUNC_UNUSED, 32'hFFFF_FFFF);
        queue_op(FUNC_PUSH,   32'hFFFF_FFFF);
        queue_op(FUNC_PUSH,   32'h0000_0000);
        queue_op(FUNC_PUSH,   32'hA5A5_5A5A);
        queue_op(FUNC_UNUSED, 32'h1234_5678);
        queue_op(FUNC_POP,    32'hFFFF_FFFF);
        queue_op(FUNC_STEAL,  32'h0000_0000);
        queue_op(FUNC_PUSH,   32'h8000_0001);
        queue_op(FUNC_STEAL,  32'h0000_0000);
        queue_op(FUNC_POP,    32'h0000_0000);
        queue_op(FUNC_POP,    32'h0000_0000);
        queue_op(FUNC_STEAL,  32'h0000_0000);

        // Random part. Each episode leans toward filling, draining or
        // mixing. Beats with the unused code do not count toward RANDOM_OPS.
        counted = 0;
        while (counted < RANDOM_OPS)
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 40);
            for (int k = 0; k < span; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    op = FUNC_UNUSED;
                end
                else
                begin
                    case (mode)
                        0:       op = ($urandom_range(0, 3) != 0) ? FUNC_PUSH
                                      : (roll[0] ? FUNC_POP : FUNC_STEAL);
                        1:       op = ($urandom_range(0, 3) == 0) ? FUNC_PUSH
                                      : (roll[0] ? FUNC_POP : FUNC_STEAL);
                        2:       op = ($urandom_range(0, 1) == 0) ? FUNC_PUSH : FUNC_STEAL;
                        default: op = FUNC_UNUSED;
                    endcase
                    if (op == FUNC_UNUSED)
                    begin
                        op = FUNC_W'($urandom_range(0, 2));
                    end
                    counted++;
                end
                case ($urandom_range(0, 15))
                    0:       job = '0;
                    1:       job = '1;
                    default: job = $urandom;
                endcase
                queue_op(op, job);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_ops < total_ops || expected_results.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // Request driver. The next beat is loaded once the current one has been
    // taken, or when nothing is on the channel. Idle bursts are inserted
    // only while the tail of the run is still far off.
    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_beat_taken))
        begin
            if (req_calm_left > 0)
            begin
                req_calm_left--;
            end
            if (req_gap_left > 0)
            begin
                req_gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_ops.size() > QUIET_TAIL && req_calm_left == 0
                     && $urandom_range(0, 5) == 0)
            begin
                req_gap_left = $urandom_range(0, 2);
                if ($urandom_range(0, 7) == 0)
                begin
                    req_calm_left = $urandom_range(20, 80);
                end
                req_ch.valid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                next_op = pending_ops.pop_front();
                req_ch.valid  <= 1'b1;
                req_ch.func   <= next_op.func;
                req_ch.job_in <= next_op.job;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response driver. Stalls come in short bursts and stop near the end.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_calm_left > 0)
            begin
                rsp_calm_left--;
            end
            if (rsp_gap_left > 0)
            begin
                rsp_gap_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (pending_ops.size() > QUIET_TAIL && rsp_calm_left == 0
                     && $urandom_range(0, 4) == 0)
            begin
                rsp_gap_left = $urandom_range(0, 2);
                if ($urandom_range(0, 7) == 0)
                begin
                    rsp_calm_left = $urandom_range(20, 80);
                end
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor. Responses are checked before the request of the same edge
    // updates the model. The response latency keeps them apart anyway.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_beat_taken <= req_ch.valid && req_ch.ready;

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    note_mismatch("unexpected response, job_out", '0, rsp_ch.job_out);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        note_mismatch("status", JOB_WIDTH'(want.status),
                                      JOB_WIDTH'(rsp_ch.status));
                    end
                    if (rsp_ch.job_out !== want.job_out)
                    begin
                        note_mismatch("job_out", want.job_out, rsp_ch.job_out);
                    end
                end
            end

            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(apply_deque_op(req_ch.func, req_ch.job_in));
                accepted_ops++;
            end
        end
    end

endmodule
